>>> rtl/pfs_pkg.sv
// Package with the constants and types shared by the fiber scheduler files.
package pfs_pkg;

    localparam int MaxFibers = 16;
    localparam int PrioBits  = 8;
    localparam int IdW       = 4;
    localparam int CntW      = 5;

    typedef enum logic [1:0] {
        ST_SUSPENDED = 2'd0,
        ST_READY     = 2'd1,
        ST_RESUMED   = 2'd2,
        ST_CURRENT   = 2'd3
    } t_fstate;

    typedef enum logic [1:0] {
        MODE_RESUME  = 2'd0,
        MODE_SUSPEND = 2'd1,
        MODE_SPAWN   = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDTGT,
        S_TGT,
        S_SCAN_RD,
        S_SCAN,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT,
        S_POP_RD,
        S_POP,
        S_POPSH_RD,
        S_POPSH,
        S_DONE
    } t_state;

endpackage

>>> rtl/priority_fiber_scheduler.sv
// Fiber scheduler top level: fiber table and ordered ready queue in memories.
//  channel | signals                                             | dir
//  command | i_start, o_busy, i_mode, i_fiber_id, i_priority_req | in (o_busy out)
//  result  | o_valid, o_current_fiber, o_switched, o_empty_error,| out
//          | o_ready_count                                       |
// The ordered insert walks the queue memory one entry at a time and the pop
// shifts it one entry at a time.
// After reset a clearing pass sweeps the fiber table while
// busy is high. The result strobe lasts one cycle; the receiver cannot stall.
module priority_fiber_scheduler
    import pfs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_mode,
    input  logic [IdW-1:0]      i_fiber_id,
    input  logic [7:0]          i_priority_req,
    output logic                o_valid,
    output logic [IdW-1:0]      o_current_fiber,
    output logic                o_switched,
    output logic                o_empty_error,
    output logic [CntW-1:0]     o_ready_count
);

    // Fiber table: state and priority per entry.
    logic [PrioBits+1:0] r_ftab [MaxFibers];
    logic [IdW-1:0]      r_qmem [MaxFibers];

    t_state r_st, n_st;
    logic [IdW-1:0]  r_id, n_id;
    logic [1:0]      r_mode, n_mode;
    logic [PrioBits-1:0] r_prio, n_prio;
    logic [IdW-1:0]  r_run, n_run;
    logic [CntW-1:0] r_len, n_len;
    logic [CntW-1:0] r_pos, n_pos;
    logic [CntW-1:0] r_k, n_k;
    logic [IdW-1:0]  r_held, n_held;
    logic            r_sw, n_sw, r_err, n_err;

    // Memory ports.
    logic                ft_we;
    logic [IdW-1:0]      ft_wa, ft_ra;
    logic [PrioBits+1:0] ft_wd, ft_rd;
    logic                q_we;
    logic [IdW-1:0]      q_wa, q_ra, q_rd;
    logic [IdW-1:0]      q_wd;

    always_ff @(posedge i_clk) begin
        if (ft_we) begin
            r_ftab[ft_wa] <= ft_wd;
        end
        ft_rd <= r_ftab[ft_ra];
        if (q_we) begin
            r_qmem[q_wa] <= q_wd;
        end
        q_rd <= r_qmem[q_ra];
    end

    logic [1:0]          rd_state;
    logic [PrioBits-1:0] rd_prio;
    assign rd_state = ft_rd[PrioBits+1:PrioBits];
    assign rd_prio  = ft_rd[PrioBits-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLEAR;
            r_run <= '0;
            r_len <= '0;
            r_k   <= '0;
        end else begin
            r_st  <= n_st;
            r_run <= n_run;
            r_len <= n_len;
            r_k   <= n_k;
        end
        r_id       <= n_id;
        r_mode     <= n_mode;
        r_prio     <= n_prio;
        r_pos      <= n_pos;
        r_held     <= n_held;
        r_sw       <= n_sw;
        r_err      <= n_err;
    end

    // Next state and datapath sequencing.
    always_comb begin
        n_st = r_st; n_id = r_id; n_mode = r_mode; n_prio = r_prio;
        n_run = r_run; n_len = r_len; n_pos = r_pos; n_k = r_k;
        n_held = r_held; n_sw = r_sw; n_err = r_err;
        ft_we = 1'b0; ft_wa = r_id; ft_wd = '0; ft_ra = r_id;
        q_we = 1'b0; q_wa = r_pos[IdW-1:0]; q_wd = r_id; q_ra = '0;
        case (r_st)
            S_CLEAR: begin
                ft_we = 1'b1;
                ft_wa = r_k[IdW-1:0];
                ft_wd = {ST_SUSPENDED, {PrioBits{1'b0}}};
                n_k   = r_k + 1'b1;
                if (r_k == CntW'(MaxFibers - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_mode = i_mode;
                    n_prio = i_priority_req[PrioBits-1:0];
                    n_sw = 1'b0; n_err = 1'b0;
                    n_id = (t_mode'(i_mode) == MODE_SUSPEND) ? r_run : i_fiber_id;
                    n_st = (t_mode'(i_mode) == MODE_NONE) ? S_DONE : S_RDTGT;
                end
            end
            S_RDTGT: begin
                ft_ra = r_id;
                n_st  = S_TGT;
            end
            S_TGT: begin
                ft_we = 1'b1;
                ft_wa = r_id;
                n_st  = S_DONE;
                if (t_mode'(r_mode) == MODE_SUSPEND) begin
                    if (t_fstate'(rd_state) == ST_RESUMED) begin
                        ft_wd  = {ST_READY, rd_prio};
                        n_prio = rd_prio;
                        n_pos  = '0;
                        n_st   = (r_len >= CntW'(MaxFibers)) ? S_POP_RD : S_SCAN_RD;
                    end else begin
                        ft_wd = {ST_SUSPENDED, rd_prio};
                        n_st  = S_POP_RD;
                    end
                end else begin
                    if (t_mode'(r_mode) == MODE_RESUME) begin
                        n_prio = rd_prio;
                    end
                    if (t_fstate'(rd_state) == ST_SUSPENDED) begin
                        ft_wd = {ST_READY, n_prio};
                        n_pos = '0;
                        if (r_len < CntW'(MaxFibers)) begin
                            n_st = S_SCAN_RD;
                        end
                    end else begin
                        ft_wd = {ST_RESUMED, n_prio};
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_pos == r_len) begin
                    n_k  = r_len;
                    n_st = S_SHIFT_RD;
                end else begin
                    q_ra = r_pos[IdW-1:0];
                    n_st = S_SCAN;
                end
            end
            S_SCAN: begin
                ft_ra = q_rd;
                n_st  = S_CMP;
            end
            S_CMP: begin
                // Priority of the queue entry is now on the table port.
                if (rd_prio <= r_prio) begin
                    n_pos = r_pos + 1'b1;
                    n_st  = S_SCAN_RD;
                end else begin
                    n_k  = r_len;
                    n_st = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_k == r_pos) begin
                    q_we  = 1'b1;
                    q_wa  = r_pos[IdW-1:0];
                    q_wd  = r_id;
                    n_len = r_len + 1'b1;
                    n_st  = (t_mode'(r_mode) == MODE_SUSPEND) ? S_POP_RD : S_DONE;
                end else begin
                    q_ra = IdW'(r_k - 1'b1);
                    n_st = S_SHIFT;
                end
            end
            S_SHIFT: begin
                q_we = 1'b1;
                q_wa = r_k[IdW-1:0];
                q_wd = q_rd;
                n_k  = r_k - 1'b1;
                n_st = S_SHIFT_RD;
            end
            S_POP_RD: begin
                q_ra = '0;
                if (r_len == '0) begin
                    n_err = 1'b1;
                    n_st  = S_DONE;
                end else begin
                    n_st = S_POP;
                end
            end
            S_POP: begin
                n_held = q_rd;
                ft_ra  = q_rd;
                n_k    = 5'd1;
                n_st   = S_POPSH_RD;
            end
            S_POPSH_RD: begin
                if (r_k == r_len) begin
                    ft_we = 1'b1;
                    ft_wa = r_held;
                    ft_wd = {ST_CURRENT, rd_prio};
                    n_len = r_len - 1'b1;
                    if (r_held != r_id) begin
                        n_run = r_held;
                        n_sw  = 1'b1;
                    end
                    n_st = S_DONE;
                end else begin
                    ft_ra = r_held;
                    q_ra  = r_k[IdW-1:0];
                    n_st  = S_POPSH;
                end
            end
            S_POPSH: begin
                ft_ra = r_held;
                q_we  = 1'b1;
                q_wa  = IdW'(r_k - 1'b1);
                q_wd  = q_rd;
                n_k   = r_k + 1'b1;
                n_st  = S_POPSH_RD;
            end
            S_DONE: begin
                n_k  = '0;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_busy          = (r_st != S_IDLE);
        o_valid         = (r_st == S_DONE);
        o_current_fiber = r_run;
        o_switched      = r_sw;
        o_empty_error   = r_err;
        o_ready_count   = r_len;
    end

endmodule

>>> rtl/pfs_checker.sv
// Port-level checker for the fiber scheduler, bound to the top level.
module pfs_checker
    import pfs_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_start,
    input logic            o_busy,
    input logic            o_valid,
    input logic            o_switched,
    input logic            o_empty_error,
    input logic [CntW-1:0] o_ready_count
);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready_count <= CntW'(MaxFibers)) else $error("ready count out of range");

    a_sw_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_switched && o_empty_error)) else $error("switch with error");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result while idle");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("no busy after start");

endmodule

bind priority_fiber_scheduler pfs_checker u_pfs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_valid(o_valid), .o_switched(o_switched), .o_empty_error(o_empty_error),
    .o_ready_count(o_ready_count)
);
